// ===== sv/mouse_report_delta_accumulator_unit_assert.svh =====
// Assertion macros shared by the mouse report delta accumulator RTL.
`ifndef MOUSE_REPORT_DELTA_ACCUMULATOR_UNIT_ASSERT_SVH
`define MOUSE_REPORT_DELTA_ACCUMULATOR_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define MRDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MRDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mrda_pkg.sv =====
// Package with request codes, mode codes and a helper function for the mouse report accumulator.
package mrda_pkg;

    typedef logic [1:0] t_req;
    typedef logic [1:0] t_xy_mode;
    typedef logic [1:0] t_cfg_index;

    localparam t_req REQ_DECODE     = 2'd0;
    localparam t_req REQ_READ       = 2'd1;
    localparam t_req REQ_DISCONNECT = 2'd2;

    localparam t_xy_mode XY_MODE_ABS  = 2'd0;
    localparam t_xy_mode XY_MODE_PAIR = 2'd1;

    localparam t_cfg_index CFG_XY_MODE    = 2'd0;
    localparam t_cfg_index CFG_MOUSE_TYPE = 2'd1;

    localparam int CFG_DATA_WIDTH = 4;
    localparam int OUT_DELTA_WIDTH = 32;

    // Value of one payload word in the delta modes: two signed bytes summed, or a signed word.
    function automatic logic signed [16:0] mode_value(input t_xy_mode mode, input logic [15:0] v);
        logic signed [16:0] hi;
        logic signed [16:0] lo;
        logic signed [16:0] res;
        hi = 17'(signed'(v[15:8]));
        lo = 17'(signed'(v[7:0]));
        if (mode == XY_MODE_PAIR) begin
            res = hi + lo;
        end else begin
            res = 17'(signed'(v));
        end
        return res;
    endfunction

endpackage

// ===== sv/mouse_report_delta_accumulator_unit.sv =====
// Top level of the mouse report delta accumulator: state update, output register and checks.

// Decodes mouse snapshots into button state, sticky button edges, the latest
// report counter and accumulated X/Y motion, and returns that state on a read
// request while clearing the motion and the edges. The block sustains one
// transfer per clock except while a read request is held off; the whole state
// update is one combinational step into the state registers. A read result
// appears in the output register on the cycle after its transfer. Snapshot
// and disconnect requests are still taken while a read result waits in the
// output register; a read request is held off only while the output register
// is full and stalled. The motion accumulators are ACC_WIDTH bits wide and
// wrap; dx and dy are their sign-extended values cut to 32 bits.
// Configuration may be written only while the block is idle.
module mouse_report_delta_accumulator_unit
    import mrda_pkg::*;
#(
    parameter int ACC_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   i_cfg_data,

    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [3:0]                  i_device_type,
    input  logic [15:0]                 i_report_counter,
    input  logic [15:0]                 i_button_bits,
    input  logic [15:0]                 i_raw_x,
    input  logic [15:0]                 i_raw_y,

    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_present,
    output logic [15:0]                 o_buttons_now,
    output logic [15:0]                 o_press_edges,
    output logic [15:0]                 o_release_edges,
    output logic [15:0]                 o_counter_seen,
    output logic signed [31:0]          o_dx,
    output logic signed [31:0]          o_dy
);

    t_xy_mode r_xy_mode;
    logic [3:0] r_mouse_type;

    logic r_present, n_present;
    logic r_seen, n_seen;
    logic [15:0] r_buttons, n_buttons;
    logic [15:0] r_pressed, n_pressed;
    logic [15:0] r_released, n_released;
    logic [15:0] r_counter, n_counter;
    logic [ACC_WIDTH-1:0] r_acc_x, n_acc_x;
    logic [ACC_WIDTH-1:0] r_acc_y, n_acc_y;
    logic [15:0] r_last_x, n_last_x;
    logic [15:0] r_last_y, n_last_y;
    logic [15:0] r_cred_x, n_cred_x;
    logic [15:0] r_cred_y, n_cred_y;

    logic r_out_valid;
    logic r_out_present;
    logic [15:0] r_out_buttons;
    logic [15:0] r_out_pressed;
    logic [15:0] r_out_released;
    logic [15:0] r_out_counter;
    logic signed [OUT_DELTA_WIDTH-1:0] r_out_dx;
    logic signed [OUT_DELTA_WIDTH-1:0] r_out_dy;

    logic in_xfer;
    logic out_xfer;
    logic out_blocked;
    logic read_xfer;
    logic [15:0] diff_x;
    logic [15:0] diff_y;
    logic signed [16:0] mv_x;
    logic signed [16:0] mv_y;
    logic signed [16:0] mv_cred_x;
    logic signed [16:0] mv_cred_y;
    logic signed [16:0] step_x;
    logic signed [16:0] step_y;
    logic [63:0] acc_x_wide;
    logic [63:0] acc_y_wide;
    logic state_cleared;
    logic absent_idle;

    assign out_blocked = r_out_valid && i_out_stall;
    assign o_in_stall  = out_blocked && (i_req_type == REQ_READ);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = r_out_valid && !i_out_stall;
    assign read_xfer   = in_xfer && (i_req_type == REQ_READ);

    assign diff_x    = i_raw_x - r_last_x;
    assign diff_y    = i_raw_y - r_last_y;
    assign mv_x      = mode_value(r_xy_mode, i_raw_x);
    assign mv_y      = mode_value(r_xy_mode, i_raw_y);
    assign mv_cred_x = mode_value(r_xy_mode, r_cred_x);
    assign mv_cred_y = mode_value(r_xy_mode, r_cred_y);

    assign acc_x_wide = 64'(signed'(r_acc_x));
    assign acc_y_wide = 64'(signed'(r_acc_y));

    always_comb begin
        n_present  = r_present;
        n_seen     = r_seen;
        n_buttons  = r_buttons;
        n_pressed  = r_pressed;
        n_released = r_released;
        n_counter  = r_counter;
        n_acc_x    = r_acc_x;
        n_acc_y    = r_acc_y;
        n_last_x   = r_last_x;
        n_last_y   = r_last_y;
        n_cred_x   = r_cred_x;
        n_cred_y   = r_cred_y;
        step_x     = '0;
        step_y     = '0;

        if (in_xfer) begin
            case (i_req_type)
                REQ_DECODE: begin
                    if (i_device_type != r_mouse_type) begin
                        n_present  = 1'b0;
                        n_seen     = 1'b0;
                        n_buttons  = '0;
                        n_released = r_released | r_buttons;
                        n_counter  = '0;
                        n_acc_x    = '0;
                        n_acc_y    = '0;
                        n_cred_x   = '0;
                        n_cred_y   = '0;
                    end else begin
                        n_present  = 1'b1;
                        n_seen     = 1'b1;
                        n_buttons  = i_button_bits;
                        n_pressed  = r_pressed | (i_button_bits & ~r_buttons);
                        n_released = r_released | (~i_button_bits & r_buttons);
                        n_counter  = i_report_counter;
                        if (!r_seen) begin
                            n_last_x = i_raw_x;
                            n_last_y = i_raw_y;
                            n_cred_x = i_raw_x;
                            n_cred_y = i_raw_y;
                        end else if (i_report_counter != r_counter) begin
                            if (r_xy_mode == XY_MODE_ABS) begin
                                step_x = 17'(signed'(diff_x));
                                step_y = 17'(signed'(diff_y));
                            end else begin
                                step_x   = mv_x;
                                step_y   = mv_y;
                                n_cred_x = i_raw_x;
                                n_cred_y = i_raw_y;
                            end
                            n_last_x = i_raw_x;
                            n_last_y = i_raw_y;
                        end else if (r_xy_mode != XY_MODE_ABS &&
                                     (i_raw_x != r_cred_x || i_raw_y != r_cred_y)) begin
                            step_x   = mv_x - mv_cred_x;
                            step_y   = mv_y - mv_cred_y;
                            n_cred_x = i_raw_x;
                            n_cred_y = i_raw_y;
                            n_last_x = i_raw_x;
                            n_last_y = i_raw_y;
                        end
                        n_acc_x = r_acc_x + ACC_WIDTH'(step_x);
                        n_acc_y = r_acc_y + ACC_WIDTH'(step_y);
                    end
                end
                REQ_READ: begin
                    n_acc_x    = '0;
                    n_acc_y    = '0;
                    n_pressed  = '0;
                    n_released = '0;
                end
                REQ_DISCONNECT: begin
                    n_present  = 1'b0;
                    n_seen     = 1'b0;
                    n_buttons  = '0;
                    n_released = r_released | r_buttons;
                    n_counter  = '0;
                    n_acc_x    = '0;
                    n_acc_y    = '0;
                    n_cred_x   = '0;
                    n_cred_y   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xy_mode    <= XY_MODE_ABS;
            r_mouse_type <= '0;
            r_present    <= 1'b0;
            r_seen       <= 1'b0;
            r_buttons    <= '0;
            r_pressed    <= '0;
            r_released   <= '0;
            r_counter    <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_cred_x     <= '0;
            r_cred_y     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_XY_MODE:    r_xy_mode    <= i_cfg_data[1:0];
                    CFG_MOUSE_TYPE: r_mouse_type <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
            r_present  <= n_present;
            r_seen     <= n_seen;
            r_buttons  <= n_buttons;
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_counter  <= n_counter;
            r_acc_x    <= n_acc_x;
            r_acc_y    <= n_acc_y;
            r_last_x   <= n_last_x;
            r_last_y   <= n_last_y;
            r_cred_x   <= n_cred_x;
            r_cred_y   <= n_cred_y;
            if (read_xfer) begin
                r_out_valid <= 1'b1;
            end else if (out_xfer) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (read_xfer) begin
            r_out_present  <= r_present;
            r_out_buttons  <= r_buttons;
            r_out_pressed  <= r_pressed;
            r_out_released <= r_released;
            r_out_counter  <= r_counter;
            r_out_dx       <= acc_x_wide[OUT_DELTA_WIDTH-1:0];
            r_out_dy       <= acc_y_wide[OUT_DELTA_WIDTH-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_present       = r_out_present;
    assign o_buttons_now   = r_out_buttons;
    assign o_press_edges   = r_out_pressed;
    assign o_release_edges = r_out_released;
    assign o_counter_seen  = r_out_counter;
    assign o_dx            = r_out_dx;
    assign o_dy            = r_out_dy;

    assign state_cleared = (r_acc_x == '0) && (r_acc_y == '0) &&
                           (r_pressed == '0) && (r_released == '0);
    assign absent_idle   = (r_acc_x == '0) && (r_acc_y == '0) && !r_seen;

`include "mouse_report_delta_accumulator_unit_assert.svh"

    `MRDA_ASSERT_NEXT(a_read_loads_result, read_xfer, r_out_valid, "read did not load a result")
    `MRDA_ASSERT_NEXT(a_read_clears, read_xfer, state_cleared, "read left motion or edges")
    `MRDA_ASSERT_NOW(a_absent_no_motion, !r_present, absent_idle, "motion held with no mouse")
    `MRDA_ASSERT_NOW(a_stall_when_full, o_in_stall, out_blocked, "stall without a blocked result")

endmodule
